@@ sv/aes_pkg.sv @@
// Package for the AES block cipher core: state type, S-box tables and the
// round transforms shared by the pipeline. No dependencies.
package aes_pkg;

   // Sixteen state bytes, byte 0 in the most significant position.
   typedef logic [0:15][7:0] state_type;

   // Transaction kinds carried on the request tuser field.
   typedef enum logic [1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_ENCRYPT = 2'd1,
      FUNC_DECRYPT = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   localparam logic [3:0] MIN_ROUNDS = 4'd10;

   localparam logic [0:255][7:0] FWD_SBOX = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [0:255][7:0] INV_SBOX = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   // Multiply by x in GF(2^8).
   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic state_type sub_bytes(input state_type s, input logic inverse);
      state_type t;
      for (int i = 0; i < 16; i++) begin
         t[i] = inverse ? INV_SBOX[s[i]] : FWD_SBOX[s[i]];
      end
      return t;
   endfunction

   // Row r of the state rotates left by r columns, right for the inverse.
   function automatic state_type shift_rows(input state_type s, input logic inverse);
      state_type t;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (inverse) begin
               t[r + 4 * ((c + r) % 4)] = s[r + 4 * c];
            end else begin
               t[r + 4 * c] = s[r + 4 * ((c + r) % 4)];
            end
         end
      end
      return t;
   endfunction

   function automatic state_type mix_columns(input state_type s, input logic inverse);
      state_type t;
      logic [7:0] a1 [4];
      logic [7:0] a2 [4];
      logic [7:0] a4 [4];
      logic [7:0] a8 [4];
      logic [7:0] m [4][4];
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a1[k] = s[4 * c + k];
            a2[k] = xtime(a1[k]);
            a4[k] = xtime(a2[k]);
            a8[k] = xtime(a4[k]);
            // Products by the four matrix coefficients: 2,3,1,1 or 14,11,13,9.
            if (inverse) begin
               m[k][0] = a8[k] ^ a4[k] ^ a2[k];
               m[k][1] = a8[k] ^ a2[k] ^ a1[k];
               m[k][2] = a8[k] ^ a4[k] ^ a1[k];
               m[k][3] = a8[k] ^ a1[k];
            end else begin
               m[k][0] = a2[k];
               m[k][1] = a2[k] ^ a1[k];
               m[k][2] = a1[k];
               m[k][3] = a1[k];
            end
         end
         for (int r = 0; r < 4; r++) begin
            t[4 * c + r] = m[0][(4 - r) % 4] ^ m[1][(5 - r) % 4]
                         ^ m[2][(6 - r) % 4] ^ m[3][(7 - r) % 4];
         end
      end
      return t;
   endfunction

endpackage

@@ sv/aes_block_encrypt_decrypt.sv @@
// Top level of the AES block cipher core: round key store and the unrolled
// round pipeline. Depends on aes_pkg for tables and round transforms.
//
// One block enters per cycle while the output register is free or being
// taken, passing one register stage per round step (initial key add, up to
// MAX_ROUND_KEYS-2 full rounds, final round); shorter round counts pass the
// unused stages through unchanged, so latency does not depend on num_rounds.
// A key load transaction is taken only when the pipeline holds no block, so
// blocks in flight always see the keys they entered with. Key store entries
// must be written before a block uses them. No clearing pass after reset.
module aes_block_encrypt_decrypt
   import aes_pkg::*;
#(
   parameter int MAX_ROUND_KEYS = 15
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [3:0]   csr_wr_data,     // num_rounds
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,       // key_slot[4:0], data_hi[68:5], data_lo[132:69]
   input  logic [1:0]   req_tuser,       // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata        // out_hi[63:0], out_lo[127:64]
);

   localparam int DEPTH  = 2 * MAX_ROUND_KEYS;
   localparam int STAGES = MAX_ROUND_KEYS;
   localparam logic [3:0] MAX_NR = 4'(MAX_ROUND_KEYS - 1);

   logic [3:0]  num_rounds_ff;
   logic [63:0] key_store_ff [DEPTH];

   logic        valid_ff [STAGES];
   logic        dec_ff   [STAGES];
   state_type   st_ff    [STAGES];
   logic        valid_in [STAGES];
   logic        dec_in   [STAGES];
   state_type   st_in    [STAGES];

   logic        advance;
   logic        busy;
   logic        accept;
   logic [3:0]  nr;
   func_type    func;
   logic [4:0]  key_slot;

   assign func     = func_type'(req_tuser);
   assign key_slot = req_tdata[4:0];

   // Effective round count, clamped to the supported range.
   always_comb begin
      if (num_rounds_ff < MIN_ROUNDS) begin
         nr = MIN_ROUNDS;
      end else if (num_rounds_ff > MAX_NR) begin
         nr = MAX_NR;
      end else begin
         nr = num_rounds_ff;
      end
   end

   function automatic state_type key_pair(input logic [3:0] idx);
      return {key_store_ff[5'({idx, 1'b0})], key_store_ff[5'({idx, 1'b1})]};
   endfunction

   // Pipeline moves whenever the output register is free or being taken.
   always_comb begin
      busy = 1'b0;
      for (int s = 0; s < STAGES; s++) begin
         busy = busy | valid_ff[s];
      end
   end

   assign advance    = !valid_ff[STAGES-1] || rsp_tready;
   assign req_tready = advance && !(func == FUNC_LOAD && busy);
   assign accept     = req_tvalid && req_tready;

   // Next value of every stage.
   always_comb begin
      state_type blk;
      blk = {req_tdata[68:5], req_tdata[132:69]};
      valid_in[0] = accept && (func == FUNC_ENCRYPT || func == FUNC_DECRYPT);
      dec_in[0]   = (func == FUNC_DECRYPT);
      st_in[0]    = blk ^ key_pair((func == FUNC_DECRYPT) ? nr : 4'd0);
      for (int s = 1; s < STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
         dec_in[s]   = dec_ff[s-1];
         if (s == STAGES - 1) begin
            // Final round, no column mixing.
            if (dec_ff[s-1]) begin
               st_in[s] = sub_bytes(shift_rows(st_ff[s-1], 1'b1), 1'b1) ^ key_pair(4'd0);
            end else begin
               st_in[s] = shift_rows(sub_bytes(st_ff[s-1], 1'b0), 1'b0) ^ key_pair(nr);
            end
         end else if (4'(s) < nr) begin
            if (dec_ff[s-1]) begin
               st_in[s] = mix_columns(sub_bytes(shift_rows(st_ff[s-1], 1'b1), 1'b1)
                                      ^ key_pair(nr - 4'(s)), 1'b1);
            end else begin
               st_in[s] = mix_columns(shift_rows(sub_bytes(st_ff[s-1], 1'b0), 1'b0), 1'b0)
                          ^ key_pair(4'(s));
            end
         end else begin
            st_in[s] = st_ff[s-1];
         end
      end
   end

   // Control registers: round count and stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rounds_ff <= MIN_ROUNDS;
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         if (csr_wr_en) begin
            num_rounds_ff <= csr_wr_data;
         end
         if (advance) begin
            for (int s = 0; s < STAGES; s++) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // Payload registers of the pipeline.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < STAGES; s++) begin
            dec_ff[s] <= dec_in[s];
            st_ff[s]  <= st_in[s];
         end
      end
   end

   // Round key store writes on an accepted load transaction to a slot below DEPTH.
   always_ff @(posedge clock) begin
      if (accept && func == FUNC_LOAD && 32'(key_slot) < DEPTH) begin
         key_store_ff[key_slot] <= req_tdata[68:5];
      end
   end

   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = {st_ff[STAGES-1][8:15], st_ff[STAGES-1][0:7]};

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the AES block cipher core: a queue-fed stream driver,
// a result monitor and a behavioral AES predictor. Depends on aes_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
   import aes_pkg::*;

   localparam int KEY_ENTRIES = 30;
   localparam int PIPE_CYCLES = 15;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      func_type   func;
      logic [4:0] slot;
      logic [63:0] hi;
      logic [63:0] lo;
   } cipher_req_type;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
   } cipher_blk_type;

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic [3:0]   csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;

   aes_block_encrypt_decrypt i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // Predictor state: substitution tables, the key store and the round count.
   logic [7:0]  sub_fwd [256];
   logic [7:0]  sub_inv [256];
   logic [63:0] key_mem [KEY_ENTRIES];
   logic [3:0]  round_cfg;

   cipher_req_type pending_reqs[$];
   cipher_blk_type expected_blks[$];
   cipher_req_type driven_req;

   int  gap_left;
   int  stall_left;
   int  hold_left;
   bit  idle_on;
   bit  hold_req;
   bit  hold_done;
   int  mismatches;
   int  blocks_checked;
   int  reqs_sent;
   int  idle_cycles;
   bit  timed_out;

   function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      end
      return p;
   endfunction

   // Inverse in GF(2^8) followed by the affine map gives the forward table.
   function automatic void build_sub_tables();
      logic [7:0] v, s;
      for (int x = 0; x < 256; x++) begin
         v = 8'h01;
         for (int i = 0; i < 254; i++) v = gf_mult(v, x[7:0]);
         if (x == 0) v = 8'h00;
         s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
             ^ {v[3:0], v[7:4]} ^ 8'h63;
         sub_fwd[x] = s;
         sub_inv[s] = x[7:0];
      end
   endfunction

   function automatic void xor_round_key(ref logic [7:0] st [16], input int rnd);
      for (int i = 0; i < 8; i++) begin
         st[i]     ^= key_mem[2 * rnd][63 - 8 * i -: 8];
         st[8 + i] ^= key_mem[2 * rnd + 1][63 - 8 * i -: 8];
      end
   endfunction

   function automatic void substitute(ref logic [7:0] st [16], input bit inv);
      for (int i = 0; i < 16; i++) st[i] = inv ? sub_inv[st[i]] : sub_fwd[st[i]];
   endfunction

   // Byte r + 4c sits in row r, column c.
   function automatic void rotate_rows(ref logic [7:0] st [16], input bit inv);
      logic [7:0] t [16];
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (inv) t[r + 4 * ((c + r) % 4)] = st[r + 4 * c];
            else t[r + 4 * c] = st[r + 4 * ((c + r) % 4)];
         end
      end
      st = t;
   endfunction

   function automatic void mix_cols(ref logic [7:0] st [16], input bit inv);
      logic [7:0] coef [4];
      logic [7:0] col [4];
      logic [7:0] acc;
      if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
      else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) col[r] = st[4 * c + r];
         for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++) acc ^= gf_mult(coef[(k - r + 4) % 4], col[k]);
            st[4 * c + r] = acc;
         end
      end
   endfunction

   // Full cipher or inverse cipher on one block with the current keys.
   function automatic cipher_blk_type aes_block(input cipher_req_type rq);
      logic [7:0]     st [16];
      int             nr;
      cipher_blk_type res;
      nr = (round_cfg < 4'd10) ? 10 : (round_cfg > 4'd14) ? 14 : int'(round_cfg);
      for (int i = 0; i < 8; i++) begin
         st[i]     = rq.hi[63 - 8 * i -: 8];
         st[8 + i] = rq.lo[63 - 8 * i -: 8];
      end
      if (rq.func == FUNC_ENCRYPT) begin
         xor_round_key(st, 0);
         for (int r = 1; r < nr; r++) begin
            substitute(st, 0);
            rotate_rows(st, 0);
            mix_cols(st, 0);
            xor_round_key(st, r);
         end
         substitute(st, 0);
         rotate_rows(st, 0);
         xor_round_key(st, nr);
      end else begin
         xor_round_key(st, nr);
         for (int r = nr - 1; r > 0; r--) begin
            rotate_rows(st, 1);
            substitute(st, 1);
            xor_round_key(st, r);
            mix_cols(st, 1);
         end
         rotate_rows(st, 1);
         substitute(st, 1);
         xor_round_key(st, 0);
      end
      for (int i = 0; i < 8; i++) begin
         res.hi[63 - 8 * i -: 8] = st[i];
         res.lo[63 - 8 * i -: 8] = st[8 + i];
      end
      return res;
   endfunction

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: accepted transactions update the predictor, then the next
   // transaction or an idle burst is placed on the bus.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (csr_wr_en) round_cfg = csr_wr_data;
         if (req_tvalid && req_tready) begin
            reqs_sent++;
            case (driven_req.func)
               FUNC_LOAD: if (driven_req.slot < KEY_ENTRIES) key_mem[driven_req.slot] = driven_req.hi;
               FUNC_ENCRYPT, FUNC_DECRYPT: expected_blks.push_back(aes_block(driven_req));
               default: ;
            endcase
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left == 0 && idle_on && $urandom_range(0, 7) == 0)
               gap_left = $urandom_range(1, 6);
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               driven_req = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= driven_req.func;
               req_tdata  <= {3'b000, driven_req.lo, driven_req.hi, driven_req.slot};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected result transaction %h", rsp_tdata);
            end else begin
               cipher_blk_type exp_blk;
               exp_blk = expected_blks.pop_front();
               blocks_checked++;
               if (rsp_tdata[63:0] !== exp_blk.hi || rsp_tdata[127:64] !== exp_blk.lo) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: block %0d expected hi=%h lo=%h got hi=%h lo=%h",
                              blocks_checked, exp_blk.hi, exp_blk.lo,
                              rsp_tdata[63:0], rsp_tdata[127:64]);
               end
            end
         end
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 6);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Watchdog expired with %0d results outstanding", expected_blks.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 64'h0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void add_req(input func_type f, input logic [4:0] s,
                                   input logic [63:0] h, input logic [63:0] l);
      cipher_req_type rq;
      rq.func = f;
      rq.slot = s;
      rq.hi   = h;
      rq.lo   = l;
      pending_reqs.push_back(rq);
   endfunction

   function automatic void add_random_reqs(input int count);
      int       sel;
      func_type f;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 19);
         if ($urandom_range(0, 1) == 1) f = FUNC_ENCRYPT;
         else f = FUNC_DECRYPT;
         if (sel < 2) add_req(FUNC_LOAD, 5'($urandom_range(0, 31)), {$urandom, $urandom},
                              {$urandom, $urandom});
         else if (sel == 2) add_req(FUNC_NONE, 5'($urandom), {$urandom, $urandom},
                                    {$urandom, $urandom});
         else if (sel < 6) add_req(f, 5'($urandom), pick_word(), pick_word());
         else add_req(f, 5'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
      end
   endfunction

   // Waits until all transactions are accepted and all results have arrived.
   task automatic drain_pipeline();
      while (pending_reqs.size() > 0 || req_tvalid || expected_blks.size() > 0)
         @(posedge clock);
      repeat (PIPE_CYCLES + 5) @(posedge clock);
   endtask

   task automatic write_rounds(input logic [3:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Stimulus sequencing: key setup, directed cases, then random phases over
   // several round counts, including out-of-range values.
   initial begin
      logic [3:0] round_list [9];
      round_list = '{4'd10, 4'd12, 4'd14, 4'd15, 4'd0, 4'd11, 4'd13, 4'd9, 4'd10};
      build_sub_tables();
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 4'd0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = FUNC_NONE;
      rsp_tready  = 1'b0;
      round_cfg   = 4'd10;
      idle_on     = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Every key entry is written before any block can read it.
      for (int s = 0; s < KEY_ENTRIES; s++) add_req(FUNC_LOAD, 5'(s), {$urandom, $urandom}, '1);

      // Directed: extreme blocks, both directions, ignored loads and the unused code.
      add_req(FUNC_ENCRYPT, 5'd0, 64'h0, 64'h0);
      add_req(FUNC_DECRYPT, 5'd31, 64'h0, 64'h0);
      add_req(FUNC_ENCRYPT, 5'd31, '1, '1);
      add_req(FUNC_DECRYPT, 5'd0, '1, '1);
      add_req(FUNC_ENCRYPT, 5'd0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      add_req(FUNC_LOAD, 5'd30, '1, '1);
      add_req(FUNC_LOAD, 5'd31, 64'h0, 64'h0);
      add_req(FUNC_NONE, 5'd31, '1, '1);
      add_req(FUNC_NONE, 5'd0, 64'h0, 64'h0);
      add_req(FUNC_LOAD, 5'd0, '1, 64'h0);
      add_req(FUNC_LOAD, 5'd29, 64'h0, '1);
      add_req(FUNC_ENCRYPT, 5'd0, 64'h0123456789abcdef, 64'hfedcba9876543210);
      add_req(FUNC_DECRYPT, 5'd0, 64'h0123456789abcdef, 64'hfedcba9876543210);
      drain_pipeline();

      for (int ph = 0; ph < 9; ph++) begin
         if (ph > 0) write_rounds(round_list[ph]);
         if (ph == 8) idle_on = 1'b0;
         add_random_reqs(80);
         if (ph == 2) hold_req <= 1'b1;
         drain_pipeline();
      end

      $display("Sent %0d transactions and checked %0d cipher blocks", reqs_sent,
               blocks_checked);
      $display("Round counts 0, 9 through 15 applied, with random key reloads");
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches found", mismatches);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
